FILE: rtl/core/tgh_pkg.sv
package tgh_pkg;

	// configuration register map
	localparam int CFG_IDX_W = 3;
	localparam int COS_W     = 16;
	localparam int HOLD_W    = 16;
	localparam int STATUS_W  = 2;

	localparam logic [HOLD_W-1:0] HOLD_RST      = 16'd200;
	localparam logic [COS_W-1:0]  ENTER_COS_RST = 16'd29452;
	localparam logic [COS_W-1:0]  EXIT_COS_RST  = 16'd26510;

	// shared multiplier: 64x64 product built from four 32x32 partial products
	localparam int MUL_HALF_W = 32;
	localparam int MUL_OP_W   = 2 * MUL_HALF_W;
	localparam int MUL_PROD_W = 2 * MUL_OP_W;

	// Q15 cosine squared gives Q30, so dot^2 is scaled by 2^30
	localparam int ALIGN_SHIFT = 30;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REF_X      = 3'd0,
		REG_REF_Y      = 3'd1,
		REG_REF_Z      = 3'd2,
		REG_REF_LOADED = 3'd3,
		REG_HOLD_MS    = 3'd4,
		REG_ENTER_COS  = 3'd5,
		REG_EXIT_COS   = 3'd6
	} cfg_reg_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_NO_REF  = 2'd0,
		ST_GRAVITY = 2'd1,
		ST_ANGLE   = 2'd2
	} result_status_t;

	typedef enum logic [1:0] {
		MUL_DOT = 2'd0,
		MUL_CS  = 2'd1,
		MUL_CSR = 2'd2
	} mul_sel_t;

	// controller to datapath
	typedef struct packed {
		logic     load;
		logic     prod;
		logic     sum;
		logic     mul_start;
		mul_sel_t mul_sel;
		logic     decide;
	} tgh_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic mul_done;
		logic out_free;
	} tgh_stat_t;

endpackage

FILE: rtl/core/tgh_sample_if.sv
interface tgh_sample_if #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int TIME_WIDTH   = 32
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] accel_x;
	logic signed [SAMPLE_WIDTH-1:0] accel_y;
	logic signed [SAMPLE_WIDTH-1:0] accel_z;
	logic        [TIME_WIDTH-1:0]   time_ms;

	modport source (output valid, output accel_x, output accel_y, output accel_z,
		output time_ms, input ready);
	modport sink (input valid, input accel_x, input accel_y, input accel_z,
		input time_ms, output ready);
endinterface

FILE: rtl/core/tgh_result_if.sv
interface tgh_result_if;
	import tgh_pkg::*;

	logic                valid;
	logic                ready;
	logic                orientation_ok;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output orientation_ok, output status, input ready);
	modport sink (input valid, input orientation_ok, input status, output ready);
endinterface

FILE: rtl/core/tgh_cfg_if.sv
interface tgh_cfg_if #(
	parameter int DATA_WIDTH = 16
);
	import tgh_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [DATA_WIDTH-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/tgh_mul.sv
module tgh_mul (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [tgh_pkg::MUL_OP_W-1:0]   a,
	input  logic [tgh_pkg::MUL_OP_W-1:0]   b,
	output logic                           done,
	output logic [tgh_pkg::MUL_PROD_W-1:0] prod
);
	import tgh_pkg::*;

	localparam logic [1:0] LAST_STEP = 2'd3;

	logic [MUL_OP_W-1:0]   a_q;
	logic [MUL_OP_W-1:0]   b_q;
	logic [MUL_PROD_W-1:0] acc_q;
	logic                  busy_q;
	logic [1:0]            step_q;
	logic [MUL_HALF_W-1:0] a_half;
	logic [MUL_HALF_W-1:0] b_half;
	logic [MUL_OP_W-1:0]   part;
	logic [MUL_PROD_W-1:0] part_sh;

	// step bit 1 picks the half of a, bit 0 the half of b
	always_comb begin
		a_half = step_q[1] ? a_q[MUL_OP_W-1:MUL_HALF_W] : a_q[MUL_HALF_W-1:0];
		b_half = step_q[0] ? b_q[MUL_OP_W-1:MUL_HALF_W] : b_q[MUL_HALF_W-1:0];
		part   = MUL_OP_W'(a_half) * MUL_OP_W'(b_half);
		case (step_q) inside
			2'd0:       part_sh = MUL_PROD_W'(part);
			2'd1, 2'd2: part_sh = MUL_PROD_W'(part) << MUL_HALF_W;
			default:    part_sh = MUL_PROD_W'(part) << MUL_OP_W;
		endcase
	end

	// step sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 2'd1;
			if (step_q == LAST_STEP) begin
				busy_q <= 1'b0;
			end
		end
	end

	// operand capture and accumulation
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + part_sh;
		end
	end

	assign done = busy_q && (step_q == LAST_STEP);
	assign prod = acc_q;

endmodule

FILE: rtl/core/tgh_dp.sv
module tgh_dp #(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int TIME_WIDTH     = 32,
	parameter int GRAV_FLOOR_MG  = 800,
	parameter int GRAV_CEIL_MG   = 1200,
	parameter int CFG_DATA_W     = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tgh_pkg::tgh_cmd_t               cmd,
	output tgh_pkg::tgh_stat_t              stat,
	input  logic signed [SAMPLE_WIDTH-1:0]  accel_x,
	input  logic signed [SAMPLE_WIDTH-1:0]  accel_y,
	input  logic signed [SAMPLE_WIDTH-1:0]  accel_z,
	input  logic        [TIME_WIDTH-1:0]    time_ms,
	input  logic                            cfg_valid,
	input  logic [tgh_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]           cfg_data,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic                            orientation_ok,
	output logic [tgh_pkg::STATUS_W-1:0]    status
);
	import tgh_pkg::*;

	localparam int SQ_W   = 2 * SAMPLE_WIDTH;
	localparam int DOT_W  = SQ_W + 1;
	localparam int DOT2_W = 2 * SQ_W;
	localparam int LHS_W  = DOT2_W + ALIGN_SHIFT;
	localparam logic [63:0] LO2 = 64'(GRAV_FLOOR_MG) * 64'(GRAV_FLOOR_MG);
	localparam logic [63:0] HI2 = 64'(GRAV_CEIL_MG) * 64'(GRAV_CEIL_MG);

	// configuration
	logic signed [SAMPLE_WIDTH-1:0] ref_x_q;
	logic signed [SAMPLE_WIDTH-1:0] ref_y_q;
	logic signed [SAMPLE_WIDTH-1:0] ref_z_q;
	logic                           ref_loaded_q;
	logic [HOLD_W-1:0]              hold_q;
	logic [COS_W-1:0]               enter_cos_q;
	logic [COS_W-1:0]               exit_cos_q;

	// gate state
	logic                  gate_open_q;
	logic                  armed_q;
	logic [TIME_WIDTH-1:0] start_time_q;

	// working registers
	logic signed [SAMPLE_WIDTH-1:0] sx_q;
	logic signed [SAMPLE_WIDTH-1:0] sy_q;
	logic signed [SAMPLE_WIDTH-1:0] sz_q;
	logic [TIME_WIDTH-1:0]          now_q;
	logic [SQ_W-1:0]                sxx_q;
	logic [SQ_W-1:0]                syy_q;
	logic [SQ_W-1:0]                szz_q;
	logic [SQ_W-1:0]                rxx_q;
	logic [SQ_W-1:0]                ryy_q;
	logic [SQ_W-1:0]                rzz_q;
	logic signed [SQ_W-1:0]         pxx_q;
	logic signed [SQ_W-1:0]         pyy_q;
	logic signed [SQ_W-1:0]         pzz_q;
	logic [2*COS_W-1:0]             cos2_q;
	logic [SQ_W-1:0]                s2_q;
	logic [SQ_W-1:0]                r2_q;
	logic signed [DOT_W-1:0]        dot_q;
	logic [DOT2_W-1:0]              dot2_q;

	// output register
	logic                out_valid_q;
	logic                ok_q;
	logic [STATUS_W-1:0] status_q;

	// combinational
	logic signed [SQ_W-1:0]  sq_sx, sq_sy, sq_sz, sq_rx, sq_ry, sq_rz;
	logic signed [SQ_W-1:0]  pr_x, pr_y, pr_z;
	logic [COS_W-1:0]        cos_sel;
	logic signed [DOT_W-1:0] dot_sum;
	logic [MUL_OP_W-1:0]     mul_a, mul_b;
	logic                    mul_done;
	logic [MUL_PROD_W-1:0]   mul_prod;
	logic [MUL_PROD_W-1:0]   lhs;
	logic                    win_ok;
	logic                    above;
	logic                    gate_n, armed_n;
	logic [TIME_WIDTH-1:0]   start_n;
	logic [TIME_WIDTH-1:0]   elapsed;
	logic                    ok_n;
	result_status_t          status_n;

	// component products and the selected cosine
	assign sq_sx   = sx_q * sx_q;
	assign sq_sy   = sy_q * sy_q;
	assign sq_sz   = sz_q * sz_q;
	assign sq_rx   = ref_x_q * ref_x_q;
	assign sq_ry   = ref_y_q * ref_y_q;
	assign sq_rz   = ref_z_q * ref_z_q;
	assign pr_x    = sx_q * ref_x_q;
	assign pr_y    = sy_q * ref_y_q;
	assign pr_z    = sz_q * ref_z_q;
	assign cos_sel = gate_open_q ? exit_cos_q : enter_cos_q;
	assign dot_sum = DOT_W'(pxx_q) + DOT_W'(pyy_q) + DOT_W'(pzz_q);

	// multiplier operands
	always_comb begin
		case (cmd.mul_sel)
			MUL_DOT: begin
				mul_a = MUL_OP_W'(dot_q[SQ_W-1:0]);
				mul_b = MUL_OP_W'(dot_q[SQ_W-1:0]);
			end
			MUL_CS: begin
				mul_a = MUL_OP_W'(cos2_q);
				mul_b = MUL_OP_W'(s2_q);
			end
			MUL_CSR: begin
				mul_a = mul_prod[MUL_OP_W-1:0];
				mul_b = MUL_OP_W'(r2_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	tgh_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// cone test: nonzero |s|^2 and |r|^2, dot > 0 and dot^2 * 2^30 > cos^2 * |s|^2 * |r|^2
	assign lhs    = MUL_PROD_W'({dot2_q, {ALIGN_SHIFT{1'b0}}});
	assign win_ok = (64'(s2_q) >= LO2) && (64'(s2_q) <= HI2);
	assign above  = (s2_q != '0) && (r2_q != '0) && !dot_q[DOT_W-1] && (dot_q != '0)
		&& (lhs > mul_prod);

	// gate update
	always_comb begin
		gate_n   = gate_open_q;
		armed_n  = armed_q;
		start_n  = start_time_q;
		ok_n     = 1'b0;
		status_n = ST_NO_REF;
		elapsed  = now_q - start_time_q;
		if (!ref_loaded_q) begin
			status_n = ST_NO_REF;
		end else if (!win_ok) begin
			gate_n   = 1'b0;
			armed_n  = 1'b0;
			status_n = ST_GRAVITY;
		end else begin
			status_n = ST_ANGLE;
			if (gate_open_q) begin
				if (!above) begin
					gate_n  = 1'b0;
					armed_n = 1'b0;
				end
			end else if (above) begin
				if (!armed_q) begin
					armed_n = 1'b1;
					start_n = now_q;
				end
				elapsed = now_q - start_n;
				if (elapsed >= TIME_WIDTH'(hold_q)) begin
					gate_n  = 1'b1;
					armed_n = 1'b0;
				end
			end else begin
				armed_n = 1'b0;
			end
			ok_n = gate_n;
		end
	end

	// configuration and gate state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_x_q      <= '0;
			ref_y_q      <= '0;
			ref_z_q      <= '0;
			ref_loaded_q <= 1'b0;
			hold_q       <= HOLD_RST;
			enter_cos_q  <= ENTER_COS_RST;
			exit_cos_q   <= EXIT_COS_RST;
			gate_open_q  <= 1'b0;
			armed_q      <= 1'b0;
			start_time_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_REF_X: begin
					ref_x_q     <= cfg_data[SAMPLE_WIDTH-1:0];
					gate_open_q <= 1'b0;
					armed_q     <= 1'b0;
				end
				REG_REF_Y: begin
					ref_y_q     <= cfg_data[SAMPLE_WIDTH-1:0];
					gate_open_q <= 1'b0;
					armed_q     <= 1'b0;
				end
				REG_REF_Z: begin
					ref_z_q     <= cfg_data[SAMPLE_WIDTH-1:0];
					gate_open_q <= 1'b0;
					armed_q     <= 1'b0;
				end
				REG_REF_LOADED: begin
					ref_loaded_q <= cfg_data[0];
					gate_open_q  <= 1'b0;
					armed_q      <= 1'b0;
				end
				REG_HOLD_MS:   hold_q      <= cfg_data[HOLD_W-1:0];
				REG_ENTER_COS: enter_cos_q <= cfg_data[COS_W-1:0];
				REG_EXIT_COS:  exit_cos_q  <= cfg_data[COS_W-1:0];
				default: ;
			endcase
		end else if (cmd.decide) begin
			gate_open_q  <= gate_n;
			armed_q      <= armed_n;
			start_time_q <= start_n;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sx_q  <= accel_x;
			sy_q  <= accel_y;
			sz_q  <= accel_z;
			now_q <= time_ms;
		end
		if (cmd.prod) begin
			sxx_q  <= $unsigned(sq_sx);
			syy_q  <= $unsigned(sq_sy);
			szz_q  <= $unsigned(sq_sz);
			rxx_q  <= $unsigned(sq_rx);
			ryy_q  <= $unsigned(sq_ry);
			rzz_q  <= $unsigned(sq_rz);
			pxx_q  <= pr_x;
			pyy_q  <= pr_y;
			pzz_q  <= pr_z;
			cos2_q <= (2*COS_W)'(cos_sel) * (2*COS_W)'(cos_sel);
		end
		if (cmd.sum) begin
			s2_q  <= sxx_q + syy_q + szz_q;
			r2_q  <= rxx_q + ryy_q + rzz_q;
			dot_q <= dot_sum;
		end
		// dot^2 is still in the accumulator when the next product starts
		if (cmd.mul_start && (cmd.mul_sel == MUL_CS)) begin
			dot2_q <= mul_prod[DOT2_W-1:0];
		end
		if (cmd.decide) begin
			ok_q     <= ok_n;
			status_q <= status_n;
		end
	end

	// result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.decide) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.mul_done  = mul_done;
	assign stat.out_free  = !out_valid_q || out_ready;
	assign out_valid      = out_valid_q;
	assign orientation_ok = ok_q;
	assign status         = status_q;

endmodule

FILE: rtl/core/tgh_ctrl.sv
module tgh_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tgh_pkg::tgh_stat_t  stat,
	output tgh_pkg::tgh_cmd_t   cmd
);
	import tgh_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE    = 10'b00_0000_0001,
		S_PROD    = 10'b00_0000_0010,
		S_SUM     = 10'b00_0000_0100,
		S_DOT_GO  = 10'b00_0000_1000,
		S_DOT_RUN = 10'b00_0001_0000,
		S_CS_GO   = 10'b00_0010_0000,
		S_CS_RUN  = 10'b00_0100_0000,
		S_CSR_GO  = 10'b00_1000_0000,
		S_CSR_RUN = 10'b01_0000_0000,
		S_DECIDE  = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	state_t state_n;

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_n       = state_q;
		cmd           = '0;
		cmd.mul_sel   = MUL_DOT;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = S_PROD;
				end
			end
			S_PROD: begin
				cmd.prod = 1'b1;
				state_n  = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_n = S_DOT_GO;
			end
			S_DOT_GO: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MUL_DOT;
				state_n       = S_DOT_RUN;
			end
			S_DOT_RUN: begin
				if (stat.mul_done) begin
					state_n = S_CS_GO;
				end
			end
			S_CS_GO: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MUL_CS;
				state_n       = S_CS_RUN;
			end
			S_CS_RUN: begin
				if (stat.mul_done) begin
					state_n = S_CSR_GO;
				end
			end
			S_CSR_GO: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MUL_CSR;
				state_n       = S_CSR_RUN;
			end
			S_CSR_RUN: begin
				if (stat.mul_done) begin
					state_n = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (stat.out_free) begin
					cmd.decide = 1'b1;
					state_n    = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

FILE: rtl/core/tilt_gate_hysteresis_hold.sv
// channel   dir  handshake     payload
// sample    in   valid/ready   accel_x, accel_y, accel_z, time_ms
// result    out  valid/ready   orientation_ok, status
// cfg       in   valid/ready   index, data (always ready)
//
// one sample at a time: the next request is taken only after the result of
// the last one has been registered and the block is back in idle
// the pace is set by the shared 32x32 multiplier, which builds three 64x64
// products (dot^2, cos^2*|s|^2, then times |r|^2) at four partial products each
// a result that is not taken holds the block in its decision step
// arst_n clears the gate state and loads the register reset values
module tilt_gate_hysteresis_hold #(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int TIME_WIDTH     = 32,
	parameter int GRAV_FLOOR_MG  = 800,
	parameter int GRAV_CEIL_MG   = 1200
) (
	input  logic          clk,
	input  logic          arst_n,
	tgh_sample_if.sink    sample,
	tgh_result_if.source  result,
	tgh_cfg_if.sink       cfg
);
	import tgh_pkg::*;

	localparam int CFG_DATA_W = (SAMPLE_WIDTH > COS_W) ? SAMPLE_WIDTH : COS_W;

	tgh_cmd_t  cmd;
	tgh_stat_t stat;
	logic      in_ready;

	assign sample.ready = in_ready;
	assign cfg.ready    = 1'b1;

	// sequencer
	tgh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// arithmetic, gate state and result register
	tgh_dp #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.TIME_WIDTH     (TIME_WIDTH),
		.GRAV_FLOOR_MG  (GRAV_FLOOR_MG),
		.GRAV_CEIL_MG   (GRAV_CEIL_MG),
		.CFG_DATA_W     (CFG_DATA_W)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.accel_x        (sample.accel_x),
		.accel_y        (sample.accel_y),
		.accel_z        (sample.accel_z),
		.time_ms        (sample.time_ms),
		.cfg_valid      (cfg.valid),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data[CFG_DATA_W-1:0]),
		.out_ready      (result.ready),
		.out_valid      (result.valid),
		.orientation_ok (result.orientation_ok),
		.status         (result.status)
	);

endmodule
